// ----- src/lr_shift_reduce_parser_defines.svh -----
//------------------------------------------------------------------------------
// LR shift-reduce parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
//------------------------------------------------------------------------------
`ifndef LR_SHIFT_REDUCE_PARSER_DEFINES_SVH
`define LR_SHIFT_REDUCE_PARSER_DEFINES_SVH

// Same-cycle implication.
`define LRSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lrsr_pkg.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// LR shift-reduce parser package
// Types, widths and the ACTION / GOTO tables for the grammar S->BB, B->aB | b.
//------------------------------------------------------------------------------
`default_nettype none

package lrsr_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int STATE_W     = 4;
    localparam int HEIGHT_W    = 5;
    localparam int RULE_W      = 2;
    localparam int CODE_W      = 3;

    localparam logic [7:0] SYM_B   = 8'h62;   // 'b'
    localparam logic [7:0] SYM_END = 8'h23;   // '#'

    typedef enum logic [CODE_W-1:0] {
        ACT_SHIFT    = 3'd0,
        ACT_REDUCE   = 3'd1,
        ACT_ACCEPT   = 3'd2,
        ACT_ERROR    = 3'd3,
        ACT_OVERFLOW = 3'd4,
        ACT_IGNORED  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        COL_A   = 2'd0,
        COL_B   = 2'd1,
        COL_END = 2'd2
    } col_t;

    typedef enum logic [1:0] {
        ENT_ERR    = 2'd0,
        ENT_SHIFT  = 2'd1,
        ENT_REDUCE = 2'd2,
        ENT_ACC    = 2'd3
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t          kind;
        logic [STATE_W-1:0] arg;
    } ent_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ACT  = 2'd1,
        S_GOTO = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch input request
        logic act;    // execute table action
        logic gto;    // finish reduction with goto
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reduce;     // pending action is a legal reduction
        logic out_free;   // output register can take a result
    } dp_status_t;

    function automatic col_t col_of(input logic [7:0] sym);
        col_t c;
        if (sym == SYM_B)
            c = COL_B;
        else if (sym == SYM_END)
            c = COL_END;
        else
            c = COL_A;
        return c;
    endfunction

    function automatic ent_t act_lookup(input logic [STATE_W-1:0] st, input col_t col);
        ent_t e;
        e = '{kind: ENT_ERR, arg: '0};
        case (st)
            4'd0, 4'd3:
            begin
                case (col)
                    COL_A:   e = '{kind: ENT_SHIFT, arg: 4'd3};
                    COL_B:   e = '{kind: ENT_SHIFT, arg: 4'd4};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd1:
            begin
                case (col)
                    COL_END: e = '{kind: ENT_ACC, arg: '0};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd2, 4'd6:
            begin
                case (col)
                    COL_A:   e = '{kind: ENT_SHIFT, arg: 4'd6};
                    COL_B:   e = '{kind: ENT_SHIFT, arg: 4'd7};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd4:
            begin
                case (col)
                    COL_A, COL_B: e = '{kind: ENT_REDUCE, arg: 4'd3};
                    default:      e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd5:
            begin
                case (col)
                    COL_END: e = '{kind: ENT_REDUCE, arg: 4'd1};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd7:
            begin
                case (col)
                    COL_END: e = '{kind: ENT_REDUCE, arg: 4'd3};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd8:
            begin
                case (col)
                    COL_A, COL_B: e = '{kind: ENT_REDUCE, arg: 4'd2};
                    default:      e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            4'd9:
            begin
                case (col)
                    COL_END: e = '{kind: ENT_REDUCE, arg: 4'd2};
                    default: e = '{kind: ENT_ERR, arg: '0};
                endcase
            end
            default: e = '{kind: ENT_ERR, arg: '0};
        endcase
        return e;
    endfunction

    // lhs: 0 = S, 1 = B
    function automatic logic [STATE_W-1:0] goto_lookup(input logic [STATE_W-1:0] st,
                                                       input logic lhs);
        logic [STATE_W-1:0] g;
        g = '0;
        if (!lhs)
        begin
            if (st == 4'd0)
                g = 4'd1;
        end
        else
        begin
            case (st)
                4'd0:    g = 4'd2;
                4'd2:    g = 4'd5;
                4'd3:    g = 4'd8;
                4'd6:    g = 4'd9;
                default: g = '0;
            endcase
        end
        return g;
    endfunction

    function automatic logic [1:0] rule_len(input logic [RULE_W-1:0] rule);
        logic [1:0] n;
        case (rule)
            2'd1, 2'd2: n = 2'd2;
            default:    n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic rule_lhs(input logic [RULE_W-1:0] rule);
        return rule[1];
    endfunction

    function automatic logic [HEIGHT_W-1:0] height_of(input logic [SP_W-1:0] sp);
        logic [SP_W:0] h;
        h = {1'b0, sp} + {{SP_W{1'b0}}, 1'b1};
        return HEIGHT_W'(h);
    endfunction

endpackage

`default_nettype wire

// ----- src/lrsr_ram.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module lrsr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/lrsr_ctrl.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// LR parser controller
// Sequences request intake, table actions and goto steps.
//------------------------------------------------------------------------------
`default_nettype none
`include "lr_shift_reduce_parser_defines.svh"

module lrsr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire lrsr_pkg::dp_status_t status,
    output lrsr_pkg::ctrl_cmd_t      cmd
);

    lrsr_pkg::state_t state_reg;
    lrsr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lrsr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrsr_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = lrsr_pkg::S_ACT;
            end
            lrsr_pkg::S_ACT:
            begin
                if (status.reduce)
                    state_next = lrsr_pkg::S_GOTO;
                else if (status.out_free)
                    state_next = lrsr_pkg::S_IDLE;
            end
            lrsr_pkg::S_GOTO:
            begin
                if (status.out_free)
                    state_next = lrsr_pkg::S_ACT;
            end
            default: state_next = lrsr_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            lrsr_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            lrsr_pkg::S_ACT:
            begin
                // a reduction only starts the stack read; no result yet
                cmd.act = status.reduce || status.out_free;
            end
            lrsr_pkg::S_GOTO:
            begin
                cmd.gto = status.out_free;
            end
            default:
            begin
                cmd      = '0;
                in_stall = 1'b1;
            end
        endcase
    end

    `LRSR_ASSERT_NXT(a_load_to_act, state_reg == lrsr_pkg::S_IDLE && in_valid,
                     state_reg == lrsr_pkg::S_ACT, "accepted request did not start action")
    `LRSR_ASSERT_NXT(a_reduce_to_goto, cmd.act && status.reduce,
                     state_reg == lrsr_pkg::S_GOTO, "reduction did not enter goto step")
    `LRSR_ASSERT_NXT(a_goto_single, cmd.gto, !cmd.gto, "goto step issued twice in a row")

endmodule

`default_nettype wire

// ----- src/lrsr_datapath.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// LR parser datapath
// State stack, table lookups and the result register.
//------------------------------------------------------------------------------
`default_nettype none
`include "lr_shift_reduce_parser_defines.svh"

module lrsr_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire lrsr_pkg::ctrl_cmd_t                 cmd,
    output lrsr_pkg::dp_status_t                    status,
    input  wire logic                               kind,
    input  wire logic [7:0]                         symbol_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [lrsr_pkg::CODE_W-1:0]             action_code,
    output logic [lrsr_pkg::RULE_W-1:0]             rule_number,
    output logic [lrsr_pkg::STATE_W-1:0]            next_state,
    output logic [lrsr_pkg::HEIGHT_W-1:0]           stack_height,
    output logic                                    last_of_run
);

    localparam int SP_W  = lrsr_pkg::SP_W;
    localparam int ST_W  = lrsr_pkg::STATE_W;

    // request latch
    logic                 kind_reg;
    lrsr_pkg::col_t       col_reg;

    // parser state
    logic [SP_W-1:0]      sp_reg,     sp_next;
    logic [ST_W-1:0]      top_reg,    top_next;
    logic                 halted_reg, halted_next;
    logic [SP_W-1:0]      base_reg,   base_next;
    logic [lrsr_pkg::RULE_W-1:0] rule_reg, rule_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    lrsr_pkg::action_t    code_reg,   code_next;
    logic [lrsr_pkg::RULE_W-1:0]   rule_out_reg, rule_out_next;
    logic [ST_W-1:0]      nstate_reg, nstate_next;
    logic [lrsr_pkg::HEIGHT_W-1:0] height_reg, height_next;
    logic                 last_reg,   last_next;
    logic                 out_load;

    // stack memory
    logic                 mem_we;
    logic [SP_W-1:0]      mem_waddr;
    logic [ST_W-1:0]      mem_wdata;
    logic                 mem_re;
    logic [ST_W-1:0]      mem_rdata;

    lrsr_pkg::ent_t       ent;
    logic [1:0]           len;
    logic                 too_few;
    logic                 stack_full;
    logic [SP_W-1:0]      sp_inc;
    logic [SP_W-1:0]      base_inc;
    logic [ST_W-1:0]      below;
    logic [ST_W-1:0]      goto_state;

    assign ent        = lrsr_pkg::act_lookup(top_reg, col_reg);
    assign len        = lrsr_pkg::rule_len(ent.arg[lrsr_pkg::RULE_W-1:0]);
    assign too_few    = sp_reg < SP_W'(len);
    assign stack_full = sp_reg == SP_W'(lrsr_pkg::STACK_DEPTH - 1);
    assign sp_inc     = sp_reg + SP_W'(1);
    assign base_inc   = base_reg + SP_W'(1);

    // entry 0 is never written and always reads as state 0
    assign below      = (base_reg == '0) ? '0 : mem_rdata;
    assign goto_state = lrsr_pkg::goto_lookup(below, lrsr_pkg::rule_lhs(rule_reg));

    assign status.reduce   = !kind_reg && !halted_reg && ent.kind == lrsr_pkg::ENT_REDUCE
                             && !too_few;
    assign status.out_free = !out_valid_reg || !out_stall;

    lrsr_ram #(
        .WIDTH (ST_W),
        .DEPTH (lrsr_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (base_next),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        sp_next       = sp_reg;
        top_next      = top_reg;
        halted_next   = halted_reg;
        base_next     = base_reg;
        rule_next     = rule_reg;
        out_load      = 1'b0;
        code_next     = code_reg;
        rule_out_next = '0;
        nstate_next   = '0;
        height_next   = lrsr_pkg::height_of(sp_reg);
        last_next     = 1'b1;
        mem_we        = 1'b0;
        mem_waddr     = sp_inc;
        mem_wdata     = '0;
        mem_re        = 1'b0;

        if (cmd.act)
        begin
            if (kind_reg)
            begin
                sp_next     = '0;
                top_next    = '0;
                halted_next = 1'b0;
                out_load    = 1'b1;
                code_next   = lrsr_pkg::ACT_IGNORED;
                height_next = lrsr_pkg::height_of('0);
            end
            else if (halted_reg)
            begin
                out_load  = 1'b1;
                code_next = lrsr_pkg::ACT_IGNORED;
            end
            else
            begin
                case (ent.kind)
                    lrsr_pkg::ENT_SHIFT:
                    begin
                        out_load = 1'b1;
                        if (stack_full)
                        begin
                            halted_next = 1'b1;
                            code_next   = lrsr_pkg::ACT_OVERFLOW;
                        end
                        else
                        begin
                            sp_next     = sp_inc;
                            top_next    = ent.arg;
                            mem_we      = 1'b1;
                            mem_waddr   = sp_inc;
                            mem_wdata   = ent.arg;
                            code_next   = lrsr_pkg::ACT_SHIFT;
                            nstate_next = ent.arg;
                            height_next = lrsr_pkg::height_of(sp_inc);
                        end
                    end
                    lrsr_pkg::ENT_REDUCE:
                    begin
                        if (too_few)
                        begin
                            out_load    = 1'b1;
                            halted_next = 1'b1;
                            code_next   = lrsr_pkg::ACT_ERROR;
                        end
                        else
                        begin
                            base_next = sp_reg - SP_W'(len);
                            rule_next = ent.arg[lrsr_pkg::RULE_W-1:0];
                            mem_re    = 1'b1;
                        end
                    end
                    lrsr_pkg::ENT_ACC:
                    begin
                        out_load    = 1'b1;
                        halted_next = 1'b1;
                        code_next   = lrsr_pkg::ACT_ACCEPT;
                    end
                    default:
                    begin
                        out_load    = 1'b1;
                        halted_next = 1'b1;
                        code_next   = lrsr_pkg::ACT_ERROR;
                    end
                endcase
            end
        end
        else if (cmd.gto)
        begin
            sp_next       = base_inc;
            top_next      = goto_state;
            mem_we        = 1'b1;
            mem_waddr     = base_inc;
            mem_wdata     = goto_state;
            out_load      = 1'b1;
            code_next     = lrsr_pkg::ACT_REDUCE;
            rule_out_next = rule_reg;
            nstate_next   = goto_state;
            height_next   = lrsr_pkg::height_of(base_inc);
            last_next     = 1'b0;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            top_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            col_reg  <= lrsr_pkg::col_of(symbol_byte);
        end
        base_reg <= base_next;
        rule_reg <= rule_next;
        if (out_load)
        begin
            code_reg     <= code_next;
            rule_out_reg <= rule_out_next;
            nstate_reg   <= nstate_next;
            height_reg   <= height_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action_code  = code_reg;
    assign rule_number  = rule_out_reg;
    assign next_state   = nstate_reg;
    assign stack_height = height_reg;
    assign last_of_run  = last_reg;

    `LRSR_ASSERT_NXT(a_goto_result, cmd.gto,
                     out_valid_reg && code_reg == lrsr_pkg::ACT_REDUCE && !last_reg,
                     "goto step did not post a reduce result")
    `LRSR_ASSERT_NXT(a_restart_clears, cmd.act && kind_reg,
                     !halted_reg && sp_reg == '0, "restart left stale parser state")
    `LRSR_ASSERT_NXT(a_top_tracks_push, mem_we, top_reg == $past(mem_wdata),
                     "top-of-stack register disagrees with pushed state")

endmodule

`default_nettype wire

// ----- src/lr_shift_reduce_parser.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// LR(1) shift-reduce parser
// Table-driven parser for S->BB, B->aB | b over a 16-entry state stack.
//------------------------------------------------------------------------------
// One request carries a symbol ('b', '#', anything else is 'a') or a restart.
// The block answers with one result per reduction (last_of_run low) and a
// final shift, accept, syntax error, overflow or ignored/restart result with
// last_of_run high. After accept, error or overflow every symbol is answered
// as ignored until a restart request. A request is latched in idle, each
// reduction takes an action step and a goto step, because the goto step
// needs the stack entry under the popped states and the stack RAM has a
// registered read, and a closing action step ends the request; output
// stalls hold any step that posts a result. One request is in flight at a
// time; a new request is taken as soon as the previous closing result is in
// the output register, even while that result still waits on out_stall. The
// top of stack lives in a register; entry 0 of the stack always reads as
// state 0, so the stack RAM needs no clearing after reset.
//------------------------------------------------------------------------------
`default_nettype none

module lr_shift_reduce_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [7:0]                    symbol_byte,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lrsr_pkg::CODE_W-1:0]        action_code,
    output logic [lrsr_pkg::RULE_W-1:0]        rule_number,
    output logic [lrsr_pkg::STATE_W-1:0]       next_state,
    output logic [lrsr_pkg::HEIGHT_W-1:0]      stack_height,
    output logic                               last_of_run
);

    lrsr_pkg::ctrl_cmd_t  cmd;
    lrsr_pkg::dp_status_t status;

    // sequencer: idle -> action -> (goto -> action)* -> idle
    lrsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // stack, table lookups and result register
    lrsr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .symbol_byte  (symbol_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action_code  (action_code),
        .rule_number  (rule_number),
        .next_state   (next_state),
        .stack_height (stack_height),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// LR shift-reduce parser testbench
// Drives symbols and restarts into the parser and checks every action that
// comes back against a cycle-free parse model of the grammar S->BB, B->aB | b.
// The model keeps its own state stack. Both channels idle at random.
//------------------------------------------------------------------------------

module tb;

    // request kinds
    localparam logic REQ_SYMBOL  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // canonical 'a'; any byte other than 'b' or '#' lands in the same column
    localparam logic [7:0] CH_A = 8'h61;

    // production numbers
    localparam logic [1:0] RULE_NONE   = 2'd0;
    localparam logic [1:0] RULE_S_BB   = 2'd1;
    localparam logic [1:0] RULE_B_AB   = 2'd2;
    localparam logic [1:0] RULE_B_TERM = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES   = 40;
    localparam int TARGET_ITEMS   = 300;

    typedef struct {
        logic       k;
        logic [7:0] sym;
    } request_t;

    typedef struct {
        lrsr_pkg::action_t             code;
        logic [lrsr_pkg::RULE_W-1:0]   rule;
        logic [lrsr_pkg::STATE_W-1:0]  nstate;
        logic [lrsr_pkg::HEIGHT_W-1:0] height;
        logic                          last;
    } parse_action_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid;
    logic                          in_stall;
    logic                          kind;
    logic [7:0]                    symbol_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic [lrsr_pkg::CODE_W-1:0]   action_code;
    logic [lrsr_pkg::RULE_W-1:0]   rule_number;
    logic [lrsr_pkg::STATE_W-1:0]  next_state;
    logic [lrsr_pkg::HEIGHT_W-1:0] stack_height;
    logic                          last_of_run;

    lr_shift_reduce_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .symbol_byte  (symbol_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action_code  (action_code),
        .rule_number  (rule_number),
        .next_state   (next_state),
        .stack_height (stack_height),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // requests waiting to be driven, and actions the parse model says are due
    request_t      symbol_q[$];
    parse_action_t action_q[$];

    int issued;            // requests queued by the stimulus
    int taken;             // requests accepted by the block
    int mismatches;
    int results_seen;
    int accepts_seen;
    int errors_seen;
    int overflows_seen;
    int ignored_seen;
    int reduces_seen;
    int longest_run;
    int run_len;

    //--------------------------------------------------------------------------
    // Parse model: private state stack, pointer and halt flag
    //--------------------------------------------------------------------------
    logic [lrsr_pkg::STATE_W-1:0] pstack[lrsr_pkg::STACK_DEPTH];
    int                           psp;
    bit                           phalted;

    // ACTION table of the 10 canonical LR(1) states
    function automatic lrsr_pkg::ent_t lr_action(input logic [lrsr_pkg::STATE_W-1:0] st,
                                                 input lrsr_pkg::col_t col);
        lrsr_pkg::ent_t e;
        e.kind = lrsr_pkg::ENT_ERR;
        e.arg  = '0;
        case (st)
            4'd0, 4'd3:
            begin
                if (col == lrsr_pkg::COL_A)
                    e = '{kind: lrsr_pkg::ENT_SHIFT, arg: 4'd3};
                else if (col == lrsr_pkg::COL_B)
                    e = '{kind: lrsr_pkg::ENT_SHIFT, arg: 4'd4};
            end
            4'd1:
            begin
                if (col == lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_ACC, arg: 4'd0};
            end
            4'd2, 4'd6:
            begin
                if (col == lrsr_pkg::COL_A)
                    e = '{kind: lrsr_pkg::ENT_SHIFT, arg: 4'd6};
                else if (col == lrsr_pkg::COL_B)
                    e = '{kind: lrsr_pkg::ENT_SHIFT, arg: 4'd7};
            end
            4'd4:
            begin
                if (col != lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_REDUCE, arg: {2'b00, RULE_B_TERM}};
            end
            4'd5:
            begin
                if (col == lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_REDUCE, arg: {2'b00, RULE_S_BB}};
            end
            4'd7:
            begin
                if (col == lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_REDUCE, arg: {2'b00, RULE_B_TERM}};
            end
            4'd8:
            begin
                if (col != lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_REDUCE, arg: {2'b00, RULE_B_AB}};
            end
            4'd9:
            begin
                if (col == lrsr_pkg::COL_END)
                    e = '{kind: lrsr_pkg::ENT_REDUCE, arg: {2'b00, RULE_B_AB}};
            end
            default: e.kind = lrsr_pkg::ENT_ERR;
        endcase
        return e;
    endfunction

    // GOTO table: to_b selects nonterminal B, otherwise S
    function automatic logic [lrsr_pkg::STATE_W-1:0] lr_goto(
        input logic [lrsr_pkg::STATE_W-1:0] st,
        input bit                           to_b);
        logic [lrsr_pkg::STATE_W-1:0] g;
        g = '0;
        if (!to_b)
            g = (st == 4'd0) ? 4'd1 : 4'd0;
        else
        begin
            case (st)
                4'd0:    g = 4'd2;
                4'd2:    g = 4'd5;
                4'd3:    g = 4'd8;
                4'd6:    g = 4'd9;
                default: g = 4'd0;
            endcase
        end
        return g;
    endfunction

    task automatic post_action(input lrsr_pkg::action_t code,
                               input logic [lrsr_pkg::RULE_W-1:0] rule,
                               input logic [lrsr_pkg::STATE_W-1:0] nstate,
                               input logic last);
        parse_action_t a;
        a.code   = code;
        a.rule   = rule;
        a.nstate = nstate;
        a.height = lrsr_pkg::HEIGHT_W'(psp + 1);
        a.last   = last;
        action_q.insert(action_q.size(), a);
    endtask

    // Runs one accepted request through the parse model and queues its actions.
    task automatic parse_request(input logic k, input logic [7:0] sym);
        lrsr_pkg::col_t               col;
        lrsr_pkg::ent_t               e;
        logic [lrsr_pkg::RULE_W-1:0]  rule;
        int                           len;
        logic [lrsr_pkg::STATE_W-1:0] g;
        bit                           done;
        if (k == REQ_RESTART)
        begin
            pstack[0] = '0;
            psp       = 0;
            phalted   = 1'b0;
            post_action(lrsr_pkg::ACT_IGNORED, RULE_NONE, '0, 1'b1);
            return;
        end
        if (phalted)
        begin
            post_action(lrsr_pkg::ACT_IGNORED, RULE_NONE, '0, 1'b1);
            return;
        end
        col  = (sym == lrsr_pkg::SYM_B)   ? lrsr_pkg::COL_B :
               (sym == lrsr_pkg::SYM_END) ? lrsr_pkg::COL_END : lrsr_pkg::COL_A;
        done = 1'b0;
        while (!done)
        begin
            e = lr_action(pstack[psp], col);
            case (e.kind)
                lrsr_pkg::ENT_SHIFT:
                begin
                    if (psp + 1 >= lrsr_pkg::STACK_DEPTH)
                    begin
                        phalted = 1'b1;
                        post_action(lrsr_pkg::ACT_OVERFLOW, RULE_NONE, '0, 1'b1);
                    end
                    else
                    begin
                        psp         = psp + 1;
                        pstack[psp] = e.arg;
                        post_action(lrsr_pkg::ACT_SHIFT, RULE_NONE, e.arg, 1'b1);
                    end
                    done = 1'b1;
                end
                lrsr_pkg::ENT_REDUCE:
                begin
                    rule = e.arg[lrsr_pkg::RULE_W-1:0];
                    len  = (rule == RULE_B_TERM) ? 1 : 2;
                    if (psp < len)
                    begin
                        // pop below the bottom: reported as a syntax error
                        phalted = 1'b1;
                        post_action(lrsr_pkg::ACT_ERROR, RULE_NONE, '0, 1'b1);
                        done = 1'b1;
                    end
                    else
                    begin
                        psp         = psp - len;
                        g           = lr_goto(pstack[psp], rule != RULE_S_BB);
                        psp         = psp + 1;
                        pstack[psp] = g;
                        post_action(lrsr_pkg::ACT_REDUCE, rule, g, 1'b0);
                    end
                end
                lrsr_pkg::ENT_ACC:
                begin
                    phalted = 1'b1;
                    post_action(lrsr_pkg::ACT_ACCEPT, RULE_NONE, '0, 1'b1);
                    done = 1'b1;
                end
                default:
                begin
                    phalted = 1'b1;
                    post_action(lrsr_pkg::ACT_ERROR, RULE_NONE, '0, 1'b1);
                    done = 1'b1;
                end
            endcase
        end
    endtask

    //--------------------------------------------------------------------------
    // Request side: bursts of random length separated by random gaps.
    // The payload only moves once the current request has been taken.
    //--------------------------------------------------------------------------
    int       burst_left;
    int       gap_left;
    request_t next_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            kind        <= REQ_SYMBOL;
            symbol_byte <= 8'h00;
            burst_left  = 0;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_request(kind, symbol_byte);
                taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (symbol_q.size() > 0)
                begin
                    next_req = symbol_q.pop_front();
                    in_valid    <= 1'b1;
                    kind        <= next_req.k;
                    symbol_byte <= next_req.sym;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // a new burst; about a quarter of them follow with no gap
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Result side: stall pattern is picked anew at regular intervals from free running,
    // scattered random stalls, and long stall stretches.
    //--------------------------------------------------------------------------
    int stall_tick;
    int stall_mode;
    int stall_run;
    bit stall_nxt;

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_side
        parse_action_t a;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_tick = 0;
            stall_mode = 0;
            stall_run  = 0;
            run_len    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (action_q.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t ns: unexpected result, expected none, actual code %0d",
                              " rule %0d state %0d height %0d last %0b"},
                             $time, action_code, rule_number, next_state, stack_height,
                             last_of_run);
                end
                else
                begin
                    a = action_q.pop_front();
                    check_field("action_code", 8'(a.code), 8'(action_code));
                    check_field("rule_number", 8'(a.rule), 8'(rule_number));
                    check_field("next_state", 8'(a.nstate), 8'(next_state));
                    check_field("stack_height", 8'(a.height), 8'(stack_height));
                    check_field("last_of_run", 8'(a.last), 8'(last_of_run));
                    case (a.code)
                        lrsr_pkg::ACT_ACCEPT:   accepts_seen++;
                        lrsr_pkg::ACT_ERROR:    errors_seen++;
                        lrsr_pkg::ACT_OVERFLOW: overflows_seen++;
                        lrsr_pkg::ACT_IGNORED:  ignored_seen++;
                        lrsr_pkg::ACT_REDUCE:   reduces_seen++;
                        default:                ;
                    endcase
                end
                run_len++;
                if (last_of_run === 1'b1)
                begin
                    if (run_len > longest_run)
                        longest_run = run_len;
                    run_len = 0;
                end
            end

            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: stall_nxt = 1'b0;
                1: stall_nxt = ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        stall_nxt = 1'b1;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_run = $urandom_range(1, 12);
                        stall_nxt = 1'b1;
                    end
                    else
                        stall_nxt = 1'b0;
                end
            endcase
            out_stall <= stall_nxt;
        end
    end

    //--------------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either channel
    //--------------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    //--------------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------------
    task automatic queue_request(input logic k, input logic [7:0] sym);
        request_t r;
        r.k   = k;
        r.sym = sym;
        symbol_q.insert(symbol_q.size(), r);
        issued++;
    endtask

    // any byte that parses as 'a'
    function automatic logic [7:0] rand_a_byte();
        logic [7:0] s;
        s = 8'($urandom_range(0, 255));
        while (s == lrsr_pkg::SYM_B || s == lrsr_pkg::SYM_END)
            s = 8'($urandom_range(0, 255));
        return s;
    endfunction

    // random symbol biased toward the three grammar columns
    function automatic logic [7:0] rand_symbol();
        logic [7:0] s;
        case ($urandom_range(0, 3))
            0:       s = rand_a_byte();
            1:       s = lrsr_pkg::SYM_B;
            2:       s = lrsr_pkg::SYM_END;
            default: s = 8'($urandom_range(0, 255));
        endcase
        return s;
    endfunction

    // hold the sender until every request is taken and every action returned
    task automatic wait_drained();
        while (taken != issued || action_q.size() != 0 || symbol_q.size() != 0)
            @(negedge clk);
    endtask

    int n_items;
    int n_a;
    int n_b;
    int shape;
    bit paused;

    initial
    begin
        issued = 0;
        taken  = 0;
        mismatches = 0;
        results_seen = 0;
        accepts_seen = 0;
        errors_seen = 0;
        overflows_seen = 0;
        ignored_seen = 0;
        reduces_seen = 0;
        longest_run = 0;
        pstack[0] = '0;
        psp       = 0;
        phalted   = 1'b0;
        paused    = 1'b0;
        n_items   = 0;

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: a complete sentence ending in accept, a symbol while halted,
        // an immediate syntax error, then a run of 'a' bytes (byte extremes and
        // neighbors of 'b' and '#') deep enough to overflow the stack.
        queue_request(REQ_RESTART, 8'hFF);
        queue_request(REQ_SYMBOL, CH_A);
        queue_request(REQ_SYMBOL, lrsr_pkg::SYM_B);
        queue_request(REQ_SYMBOL, lrsr_pkg::SYM_B);
        queue_request(REQ_SYMBOL, lrsr_pkg::SYM_END);
        queue_request(REQ_SYMBOL, 8'h00);
        queue_request(REQ_RESTART, 8'h00);
        queue_request(REQ_SYMBOL, lrsr_pkg::SYM_END);
        queue_request(REQ_RESTART, lrsr_pkg::SYM_B);
        queue_request(REQ_SYMBOL, 8'h00);
        queue_request(REQ_SYMBOL, 8'hFF);
        queue_request(REQ_SYMBOL, 8'h63);
        queue_request(REQ_SYMBOL, 8'h61);
        queue_request(REQ_SYMBOL, 8'h22);
        queue_request(REQ_SYMBOL, 8'h24);
        queue_request(REQ_SYMBOL, 8'h80);
        queue_request(REQ_SYMBOL, 8'h7F);
        queue_request(REQ_SYMBOL, 8'h01);
        queue_request(REQ_SYMBOL, 8'hFE);
        queue_request(REQ_SYMBOL, 8'h42);
        queue_request(REQ_SYMBOL, 8'hA5);
        queue_request(REQ_SYMBOL, 8'h5A);
        queue_request(REQ_SYMBOL, 8'h60);
        queue_request(REQ_SYMBOL, 8'h64);
        queue_request(REQ_SYMBOL, rand_a_byte());   // overflows here
        wait_drained();

        // Random: mostly well-formed sentences a^n b a^m b #, some broken
        // sequences, some overflow attempts and some raw noise.
        while (n_items < TARGET_ITEMS)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 6)
            begin
                // keep most sentences short; now and then go near the stack limit
                n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14)
                                                  : $urandom_range(0, 3);
                n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 13)
                                                  : $urandom_range(0, 3);
                queue_request(REQ_RESTART, 8'($urandom_range(0, 255)));
                repeat (n_a) queue_request(REQ_SYMBOL, rand_a_byte());
                queue_request(REQ_SYMBOL, lrsr_pkg::SYM_B);
                repeat (n_b) queue_request(REQ_SYMBOL, rand_a_byte());
                queue_request(REQ_SYMBOL, lrsr_pkg::SYM_B);
                queue_request(REQ_SYMBOL, lrsr_pkg::SYM_END);
                n_items += n_a + n_b + 4;
                if ($urandom_range(0, 3) == 0)
                    queue_request(REQ_SYMBOL, rand_symbol());   // lands after accept
            end
            else if (shape < 8)
            begin
                queue_request(REQ_RESTART, 8'($urandom_range(0, 255)));
                n_a = $urandom_range(1, 8);
                repeat (n_a) queue_request(REQ_SYMBOL, rand_symbol());
                n_items += n_a + 1;
            end
            else if (shape == 8)
            begin
                queue_request(REQ_RESTART, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0)
                    queue_request(REQ_SYMBOL, lrsr_pkg::SYM_B);
                repeat (15) queue_request(REQ_SYMBOL, rand_a_byte());
                n_items += 16;
            end
            else
            begin
                // noise: random kinds and bytes, with no restart in front
                n_a = $urandom_range(1, 5);
                repeat (n_a)
                    queue_request(($urandom_range(0, 5) == 0) ? REQ_RESTART : REQ_SYMBOL,
                                  8'($urandom_range(0, 255)));
                n_items += n_a;
            end
            if (!paused && n_items >= TARGET_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (action_q.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: results never arrived, expected 0 outstanding, actual %0d",
                     $time, action_q.size());
        end
        $display("Run covered %0d requests and %0d results: %0d reductions, %0d accepts,",
                 taken, results_seen, reduces_seen, accepts_seen);
        $display("%0d syntax errors, %0d overflows, %0d ignored/restart; longest run %0d results",
                 errors_seen, overflows_seen, ignored_seen, longest_run);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
